>>> hw/rtl/tspm_pkg.sv
// Shared types and constants for the transport stream sync and PAT monitor.
`timescale 1ns / 1ps

package tspm_pkg;

  localparam logic [7:0]  SYNC_GOOD      = 8'h47;
  localparam logic [15:0] GOOD_RUN_CEIL  = 16'd50000;
  localparam logic [15:0] GOOD_RUN_FOLD  = 16'd16;
  localparam logic [7:0]  ERROR_RUN_MAX  = 8'd255;
  localparam logic [12:0] PAT_PID        = 13'd0;

  localparam logic [3:0]  SYNC_CLEAR_RST = 4'd5;
  localparam logic [7:0]  SYNC_LOSS_RST  = 8'd2;
  localparam logic [15:0] PAT_TIMEOUT_RST = 16'd500;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_CLEAR_RUN = 2'd0,
    CFG_SYNC_LOSS_RUN  = 2'd1,
    CFG_PAT_TIMEOUT    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic sync_byte_error;
    logic ts_sync_loss;
    logic pat_alarm;
    logic batch_done;
  } result_t;

endpackage

>>> hw/rtl/ts_sync_and_pat_monitor.sv
// Top level of the transport stream sync-loss and PAT error monitor.
`timescale 1ns / 1ps

// Takes one packet's header facts per request and returns one alarm
// snapshot per request. Sync byte error / sync loss follow the run of good
// (0x47) and bad sync bytes; the PAT alarm is judged at each batch_last
// packet from the PID 0 packets seen in that batch and the PAT timeout.
// A request is taken every cycle unless in_stall is high (one per clock
// sustained); its result is registered in the output register, or in the
// one-entry skid stage, which takes one more request while the output
// stalls. Alarm state updates in the same cycle a request is accepted.
// Configuration writes take effect on the next accepted request; write
// them only while the block is idle. Unlisted register indexes are ignored.
module ts_sync_and_pat_monitor (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [tspm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tspm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input requests
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_sync_byte,
  input  logic [12:0]                   in_packet_pid,
  input  logic [7:0]                    in_section_table_id,
  input  logic [1:0]                    in_scrambling_bits,
  input  logic [31:0]                   in_time_ms,
  input  logic                          in_batch_last,
  // results
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_sync_byte_error,
  output logic                          out_ts_sync_loss,
  output logic                          out_pat_alarm,
  output logic                          out_batch_done
);
  import tspm_pkg::*;

  logic [3:0]  sync_clear_run_r;
  logic [7:0]  sync_loss_run_r;
  logic [15:0] pat_timeout_ms_r;

  logic    take;
  result_t res, res_out;

  // config register file, write only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_clear_run_r <= SYNC_CLEAR_RST;
      sync_loss_run_r  <= SYNC_LOSS_RST;
      pat_timeout_ms_r <= PAT_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SYNC_CLEAR_RUN: sync_clear_run_r <= cfg_wdata[3:0];
        CFG_SYNC_LOSS_RUN:  sync_loss_run_r  <= cfg_wdata[7:0];
        CFG_PAT_TIMEOUT:    pat_timeout_ms_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign take = in_valid & ~in_stall;

  tspm_sync_mon u_sync (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .sync_byte     (in_sync_byte),
    .sync_clear_run(sync_clear_run_r),
    .sync_loss_run (sync_loss_run_r),
    .sync_err_nxt  (res.sync_byte_error),
    .sync_loss_nxt (res.ts_sync_loss)
  );

  tspm_pat_mon u_pat (
    .clk             (clk),
    .rst_n           (rst_n),
    .take            (take),
    .packet_pid      (in_packet_pid),
    .section_table_id(in_section_table_id),
    .scrambling_bits (in_scrambling_bits),
    .time_ms         (in_time_ms),
    .batch_last      (in_batch_last),
    .pat_timeout_ms  (pat_timeout_ms_r),
    .pat_alarm_nxt   (res.pat_alarm)
  );

  assign res.batch_done = in_batch_last;

  tspm_out_buf u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (res),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (res_out)
  );

  assign out_sync_byte_error = res_out.sync_byte_error;
  assign out_ts_sync_loss    = res_out.ts_sync_loss;
  assign out_pat_alarm       = res_out.pat_alarm;
  assign out_batch_done      = res_out.batch_done;

endmodule

>>> hw/rtl/tspm_sync_mon.sv
// Sync byte run counters and the sync byte error / sync loss alarms.
`timescale 1ns / 1ps

module tspm_sync_mon (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] sync_byte,
  input  logic [3:0] sync_clear_run,
  input  logic [7:0] sync_loss_run,
  output logic       sync_err_nxt,
  output logic       sync_loss_nxt
);
  import tspm_pkg::*;

  logic [15:0] good_run_r, good_run_nxt, good_inc;
  logic [7:0]  error_run_r, error_run_nxt;
  logic        sync_err_r, sync_loss_r;

  always_comb begin
    good_inc      = good_run_r + 16'd1;
    good_run_nxt  = good_run_r;
    error_run_nxt = error_run_r;
    sync_err_nxt  = sync_err_r;
    sync_loss_nxt = sync_loss_r;
    if (sync_byte == SYNC_GOOD) begin
      error_run_nxt = '0;
      if (good_inc > {12'd0, sync_clear_run}) begin
        sync_err_nxt  = 1'b0;
        sync_loss_nxt = 1'b0;
      end
      good_run_nxt = (good_inc >= GOOD_RUN_CEIL) ? GOOD_RUN_FOLD : good_inc;
    end else begin
      good_run_nxt = '0;
      if (error_run_r < ERROR_RUN_MAX) begin
        error_run_nxt = error_run_r + 8'd1;
      end
      sync_err_nxt = 1'b1;
      if (error_run_nxt >= sync_loss_run) begin
        sync_loss_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      good_run_r  <= '0;
      error_run_r <= '0;
      sync_err_r  <= 1'b0;
      sync_loss_r <= 1'b0;
    end else if (take) begin
      good_run_r  <= good_run_nxt;
      error_run_r <= error_run_nxt;
      sync_err_r  <= sync_err_nxt;
      sync_loss_r <= sync_loss_nxt;
    end
  end

endmodule

>>> hw/rtl/tspm_pat_mon.sv
// Per-batch PAT checks, PAT timeout and the PAT error alarm.
`timescale 1ns / 1ps

module tspm_pat_mon (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic [12:0] packet_pid,
  input  logic [7:0]  section_table_id,
  input  logic [1:0]  scrambling_bits,
  input  logic [31:0] time_ms,
  input  logic        batch_last,
  input  logic [15:0] pat_timeout_ms,
  output logic        pat_alarm_nxt
);
  import tspm_pkg::*;

  logic        pat_alarm_r;
  logic [31:0] last_pat_time_r, last_pat_time_nxt;
  logic        saw_r, saw_nxt, issue_r, issue_nxt;
  logic        is_pat;
  logic [31:0] gap;

  always_comb begin
    is_pat            = (packet_pid == PAT_PID);
    saw_nxt           = saw_r | is_pat;
    issue_nxt         = issue_r |
                        (is_pat & ((section_table_id != 8'd0) | (scrambling_bits != 2'd0)));
    gap               = time_ms - last_pat_time_r;
    pat_alarm_nxt     = pat_alarm_r;
    last_pat_time_nxt = last_pat_time_r;
    if (batch_last) begin
      // batch end: a bad PAT alarms; with no PAT this batch, wrapping gap against the last stamp
      pat_alarm_nxt = issue_nxt | (!saw_nxt && (gap >= {16'd0, pat_timeout_ms}));
      if (saw_nxt) begin
        last_pat_time_nxt = time_ms;
      end
      saw_nxt   = 1'b0;
      issue_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_alarm_r     <= 1'b0;
      last_pat_time_r <= '0;
      saw_r           <= 1'b0;
      issue_r         <= 1'b0;
    end else if (take) begin
      pat_alarm_r     <= pat_alarm_nxt;
      last_pat_time_r <= last_pat_time_nxt;
      saw_r           <= saw_nxt;
      issue_r         <= issue_nxt;
    end
  end

endmodule

>>> hw/rtl/tspm_out_buf.sv
// Result register with a one-entry skid stage.
`timescale 1ns / 1ps

module tspm_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tspm_pkg::result_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tspm_pkg::result_t out_data
);
  import tspm_pkg::*;

  logic    out_valid_r, skid_valid_r;
  result_t out_data_r, skid_data_r;
  logic    acc, take_out;

  assign in_stall  = skid_valid_r;
  assign acc       = in_valid & ~skid_valid_r;
  assign take_out  = out_valid_r & ~out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (take_out || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= acc;
      end
    end else if (acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_out || !out_valid_r) begin
      out_data_r <= skid_valid_r ? skid_data_r : in_data;
    end
    if (acc && out_valid_r && !take_out) begin
      skid_data_r <= in_data;
    end
  end

endmodule

>>> verif/ts_sync_and_pat_monitor_test.sv
// Testbench for the transport stream sync-loss and PAT error monitor.
`timescale 1ns / 1ps

module ts_sync_and_pat_monitor_test;
  import tspm_pkg::*;

  // Unlisted register index; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  typedef struct packed {
    logic [7:0]  sync;
    logic [12:0] pid;
    logic [7:0]  tid;
    logic [1:0]  scram;
    logic [31:0] tms;
    logic        batch_end;
  } hdr_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SYNC_CLEAR_RUN;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_sync_byte = '0;
  logic [12:0]           in_packet_pid = '0;
  logic [7:0]            in_section_table_id = '0;
  logic [1:0]            in_scrambling_bits = '0;
  logic [31:0]           in_time_ms = '0;
  logic                  in_batch_last = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_sync_byte_error;
  logic                  out_ts_sync_loss;
  logic                  out_pat_alarm;
  logic                  out_batch_done;

  ts_sync_and_pat_monitor u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sync_byte        (in_sync_byte),
    .in_packet_pid       (in_packet_pid),
    .in_section_table_id (in_section_table_id),
    .in_scrambling_bits  (in_scrambling_bits),
    .in_time_ms          (in_time_ms),
    .in_batch_last       (in_batch_last),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_sync_byte_error (out_sync_byte_error),
    .out_ts_sync_loss    (out_ts_sync_loss),
    .out_pat_alarm       (out_pat_alarm),
    .out_batch_done      (out_batch_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard limit on run length; a hung handshake lands here.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Alarm predictor: thresholds as last written, plus the running state.
  // ---------------------------------------------------------------------
  logic [3:0]  clear_run_cfg = SYNC_CLEAR_RST;
  logic [7:0]  loss_run_cfg  = SYNC_LOSS_RST;
  logic [15:0] pat_tmo_cfg   = PAT_TIMEOUT_RST;

  logic [15:0] run_good = '0;
  logic [7:0]  run_bad = '0;
  logic        alarm_sync_err = 1'b0;
  logic        alarm_sync_loss = 1'b0;
  logic        alarm_pat = 1'b0;
  logic [31:0] pat_stamp = '0;
  logic        batch_has_pat = 1'b0;
  logic        batch_bad_pat = 1'b0;

  function automatic result_t update_alarms(hdr_t h);
    result_t     r;
    logic        verdict;
    logic [31:0] gap;
    if (h.sync == SYNC_GOOD) begin
      run_good = run_good + 16'd1;
      run_bad  = '0;
      // only a run longer than the clear threshold drops the sync alarms
      if (run_good > {12'd0, clear_run_cfg}) begin
        alarm_sync_err  = 1'b0;
        alarm_sync_loss = 1'b0;
      end
      if (run_good >= GOOD_RUN_CEIL) run_good = GOOD_RUN_FOLD;
    end else begin
      run_good = '0;
      if (run_bad != ERROR_RUN_MAX) run_bad = run_bad + 8'd1;
      alarm_sync_err = 1'b1;
      if (run_bad >= loss_run_cfg) alarm_sync_loss = 1'b1;
    end
    if (h.pid == PAT_PID) begin
      batch_has_pat = 1'b1;
      if (h.tid != 8'd0 || h.scram != 2'd0) batch_bad_pat = 1'b1;
    end
    if (h.batch_end) begin
      verdict = batch_bad_pat;
      if (!batch_has_pat) begin
        // wrapping difference: a time behind the stamp reads as a long gap
        gap = h.tms - pat_stamp;
        if (gap >= {16'd0, pat_tmo_cfg}) verdict = 1'b1;
      end else begin
        pat_stamp = h.tms;
      end
      alarm_pat     = verdict;
      batch_has_pat = 1'b0;
      batch_bad_pat = 1'b0;
    end
    r.sync_byte_error = alarm_sync_err;
    r.ts_sync_loss    = alarm_sync_loss;
    r.pat_alarm       = alarm_pat;
    r.batch_done      = h.batch_end;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Request driver and result monitor
  // ---------------------------------------------------------------------
  hdr_t    header_q[$];
  result_t alarm_snapshots[$];
  hdr_t    cur_hdr;
  int      n_queued = 0;
  int      n_checked = 0;
  int      fails = 0;
  int      cyc = 0;
  logic    calm;
  logic [31:0] batch_clock = '0;

  // Periodic window with no idling on either side.
  assign calm = (cyc % 3000) < 500;

  always @(posedge clk) begin
    if (rst_n) begin
      // request accepted: predict its snapshot from the header held on the bus
      if (in_valid && !in_stall) alarm_snapshots.push_back(update_alarms(cur_hdr));
      if (!in_valid || !in_stall) begin
        if (header_q.size() != 0 && (calm || $urandom_range(0, 99) >= 26)) begin
          cur_hdr             = header_q.pop_front();
          in_sync_byte        <= cur_hdr.sync;
          in_packet_pid       <= cur_hdr.pid;
          in_section_table_id <= cur_hdr.tid;
          in_scrambling_bits  <= cur_hdr.scram;
          in_time_ms          <= cur_hdr.tms;
          in_batch_last       <= cur_hdr.batch_end;
          in_valid            <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_flag(string name, logic want, logic got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0b actual %0b", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    cyc <= cyc + 1;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (alarm_snapshots.size() == 0) begin
          $display("%0t: unexpected result: expected none actual %b%b%b%b", $time,
                   out_sync_byte_error, out_ts_sync_loss, out_pat_alarm, out_batch_done);
          fails++;
        end else begin
          want = alarm_snapshots.pop_front();
          check_flag("sync_byte_error", want.sync_byte_error, out_sync_byte_error);
          check_flag("ts_sync_loss", want.ts_sync_loss, out_ts_sync_loss);
          check_flag("pat_alarm", want.pat_alarm, out_pat_alarm);
          check_flag("batch_done", want.batch_done, out_batch_done);
          n_checked++;
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 26);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_hdr(logic [7:0] s, logic [12:0] pid, logic [7:0] tid,
                          logic [1:0] sc, logic [31:0] t, logic be);
    hdr_t h;
    h = '{sync: s, pid: pid, tid: tid, scram: sc, tms: t, batch_end: be};
    header_q.push_back(h);
    n_queued++;
  endtask

  // Random header; the batch clock moves mostly forward around the timeout,
  // now and then backward or to an arbitrary point.
  function automatic hdr_t random_hdr(logic good);
    hdr_t h;
    int   r;
    h.sync = good ? SYNC_GOOD : 8'($urandom_range(0, 255));
    if (h.sync == SYNC_GOOD && !good) h.sync = h.sync ^ 8'h01;
    h.pid   = ($urandom_range(0, 99) < 30) ? PAT_PID : 13'($urandom_range(0, 8191));
    h.tid   = ($urandom_range(0, 99) < 80) ? 8'd0 : 8'($urandom_range(0, 255));
    h.scram = ($urandom_range(0, 99) < 80) ? 2'd0 : 2'($urandom_range(0, 3));
    h.batch_end = ($urandom_range(0, 99) < 25);
    if (h.batch_end) begin
      r = $urandom_range(0, 99);
      if (r < 85) batch_clock = batch_clock + $urandom_range(0, 2 * pat_tmo_cfg + 2);
      else if (r < 93) batch_clock = batch_clock - $urandom_range(1, 5000);
      else batch_clock = $urandom;
      h.tms = batch_clock;
    end else begin
      h.tms = $urandom;  // ignored off the batch end
    end
    return h;
  endfunction

  // Runs of good and bad sync bytes sized around the current thresholds.
  task automatic add_random(int n);
    int   left;
    int   len;
    int   r;
    logic good;
    left = n;
    while (left > 0) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        good = 1'b1;
        len  = $urandom_range(1, 20);
      end else if (r < 99) begin
        good = 1'b0;
        len  = ($urandom_range(0, 99) < 30) ? $urandom_range(1, loss_run_cfg + 2)
                                             : $urandom_range(1, 4);
      end else begin
        good = 1'b0;  // long run that can pin the bad run at its ceiling
        len  = $urandom_range(250, 300);
      end
      if (len > left) len = left;
      repeat (len) begin
        header_q.push_back(random_hdr(good));
        n_queued++;
      end
      left -= len;
    end
  endtask

  // Registers change only with nothing in flight.
  task automatic drain();
    while (n_checked != n_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Raw words go out; the block keeps only each register's own width.
  task automatic set_thresholds(logic [15:0] clr_w, logic [15:0] loss_w,
                                logic [15:0] tmo_w);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_SPARE;
    cfg_wdata <= 16'($urandom);
    @(posedge clk);
    cfg_index <= CFG_SYNC_CLEAR_RUN;
    cfg_wdata <= clr_w;
    @(posedge clk);
    cfg_index <= CFG_SYNC_LOSS_RUN;
    cfg_wdata <= loss_w;
    @(posedge clk);
    cfg_index <= CFG_PAT_TIMEOUT;
    cfg_wdata <= tmo_w;
    @(posedge clk);
    cfg_we <= 1'b0;
    clear_run_cfg = clr_w[3:0];
    loss_run_cfg  = loss_w[7:0];
    pat_tmo_cfg   = tmo_w;
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset thresholds: clear after 5, loss at 2, PAT timeout 500.
    push_hdr(SYNC_GOOD, PAT_PID, 8'd0, 2'd0, 32'd100, 1'b1);         // clean PAT, stamp
    push_hdr(8'h00, 13'h1FFF, 8'hFF, 2'd3, 32'hFFFF_FFFF, 1'b0);     // field extremes
    push_hdr(8'hFF, 13'd5, 8'd0, 2'd0, 32'd0, 1'b0);                 // second bad: loss
    push_hdr(8'h46, 13'd6, 8'd0, 2'd0, 32'd0, 1'b0);
    push_hdr(8'h48, 13'd7, 8'd0, 2'd0, 32'd0, 1'b0);
    repeat (5) push_hdr(SYNC_GOOD, 13'd100, 8'd0, 2'd0, $urandom, 1'b0);
    push_hdr(SYNC_GOOD, 13'd100, 8'd0, 2'd0, 32'd599, 1'b1);         // gap just inside
    push_hdr(SYNC_GOOD, 13'h0ABC, 8'd0, 2'd0, 32'd600, 1'b1);        // gap at timeout
    push_hdr(SYNC_GOOD, PAT_PID, 8'h02, 2'd0, 32'd5, 1'b0);          // wrong table id
    push_hdr(SYNC_GOOD, 13'd33, 8'd0, 2'd0, 32'd700, 1'b1);
    push_hdr(SYNC_GOOD, PAT_PID, 8'd0, 2'd2, 32'd800, 1'b1);         // scrambled PAT
    push_hdr(SYNC_GOOD, PAT_PID, 8'd0, 2'd0, 32'd900, 1'b1);
    push_hdr(SYNC_GOOD, 13'd17, 8'd0, 2'd0, 32'd50, 1'b1);           // time behind stamp
    push_hdr(SYNC_GOOD, PAT_PID, 8'd0, 2'd0, 32'hFFFF_FFFF, 1'b1);
    push_hdr(SYNC_GOOD, 13'd4, 8'd0, 2'd0, 32'h0000_01F2, 1'b1);     // wrapped, 499 gap
    push_hdr(8'h00, PAT_PID, 8'd0, 2'd0, 32'd0, 1'b0);               // PAT mid batch
    push_hdr(8'h00, 13'd9, 8'd0, 2'd0, 32'h0000_1000, 1'b1);
    drain();

    // Zero thresholds: one bad byte is loss, one good byte clears,
    // every batch without a PAT is flagged.
    set_thresholds(16'd0, 16'd0, 16'd0);
    push_hdr(8'h12, 13'd8, 8'd0, 2'd0, 32'd0, 1'b0);
    push_hdr(SYNC_GOOD, 13'd8, 8'd0, 2'd0, 32'd0, 1'b0);
    push_hdr(SYNC_GOOD, 13'd8, 8'd0, 2'd0, 32'h0000_1000, 1'b1);     // zero gap still late
    add_random(150);
    drain();

    set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_random(250);
    drain();

    set_thresholds(16'd1, 16'd1, 16'd1);
    add_random(200);
    drain();

    repeat (2) begin
      set_thresholds(16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)));
      add_random(200);
      drain();
    end

    // Long unbroken good run past the widest clear threshold, then noise.
    set_thresholds(16'd15, 16'd3, 16'd1000);
    repeat (3) push_hdr(8'h00, 13'd1, 8'd0, 2'd0, 32'd0, 1'b0);
    repeat (30) begin
      header_q.push_back(random_hdr(1'b1));
      n_queued++;
    end
    add_random(100);
    drain();

    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
